// ----- hdl/brbf_pkg.sv -----
package brbf_pkg;

    // store geometry
    localparam int DEPTH   = 4096;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = 12;
    localparam int RUN_W   = 7;
    localparam int MAX_RUN = 64;

    localparam logic [ADDR_W-1:0] CAP_MAX = ADDR_W'(DEPTH - 1);

    // input and output word layout
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_PEEK  = 2'd2,
        FN_CLEAR = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

endpackage

// ----- hdl/byte_ring_buffer_fifo_top.sv -----
// channel  | handshake                | payload
// ---------+--------------------------+------------------------------------------------
// s_*      | s_tvalid / s_tready      | tuser: func; tdata: data_byte, run_length
// m_*      | m_tvalid / m_tready      | tuser: byte_valid, status; tlast: last;
//          |                          | tdata: read_byte, stored_count, free_count
// cfg_*    | cfg_valid / cfg_ready    | cfg_data: capacity
//
// a write word is taken on its handshake; words of a run may follow back to back
// a read or peek of n bytes takes the request word, then streams n bytes at one
// per cycle while m_tready holds high, behind the registered output of the store's single read port
// all other requests produce their status word on the cycle after acceptance
// reset is asynchronous active low; the byte store is never cleared, since only
// written slots are ever read
// a stall on m_* holds the output register; one fetched byte waits behind it
module byte_ring_buffer_fifo_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [brbf_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] data_byte, [14:8] run_length
    input  logic [brbf_pkg::IN_USER_W-1:0]   s_tuser,   // [1:0] func
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [brbf_pkg::OUT_DATA_W-1:0]  m_tdata,   // [7:0] read_byte, [19:8] stored_count,
                                                        // [31:20] free_count
    output logic [brbf_pkg::OUT_USER_W-1:0]  m_tuser,   // [0] byte_valid, [1] status
    output logic                             m_tlast,
    // capacity write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [brbf_pkg::CNT_W-1:0]       cfg_data
);
    import brbf_pkg::*;

    // byte store, one write port and one registered read port
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    state_t state_reg, state_next;

    // buffer indexes and fill level
    logic [ADDR_W-1:0] cap_reg, cap_next;
    logic [ADDR_W-1:0] wi_reg, wi_next;
    logic [ADDR_W-1:0] ri_reg, ri_next;
    logic [CNT_W-1:0]  stored_reg, stored_next;

    // open write run
    logic [RUN_W-1:0]  wrem_reg, wrem_next;
    logic              adm_reg, adm_next;

    // read sequencer
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [RUN_W-1:0]  cnt_reg, cnt_next;
    logic              is_read_reg, is_read_next;
    logic [CNT_W-1:0]  req_stored_reg, req_stored_next;
    logic [CNT_W-1:0]  req_free_reg, req_free_next;

    // fetched byte waiting for the output register
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;

    // output register
    logic              out_v_reg, out_v_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_bv_reg, out_bv_next;
    logic              out_last_reg, out_last_next;
    logic              out_st_reg, out_st_next;
    logic [CNT_W-1:0]  out_stored_reg, out_stored_next;
    logic [CNT_W-1:0]  out_free_reg, out_free_next;

    // memory strobes
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // decoded input
    func_t             in_func;
    logic [7:0]        in_byte;
    logic [RUN_W-1:0]  in_len;
    logic              s_acc;
    logic              move;
    logic              out_free_slot;

    assign in_func = func_t'(s_tuser[1:0]);
    assign in_byte = s_tdata[7:0];
    assign in_len  = s_tdata[14:8];

    // output register can take a new word on this edge
    assign out_free_slot = !out_v_reg || m_tready;
    // fetched byte moves into the output register
    assign move          = pend_reg && out_free_slot;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !pend_reg && out_free_slot && !cfg_valid;
    assign s_acc     = s_tvalid && s_tready;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_free_reg, out_stored_reg, out_byte_reg};
    assign m_tuser  = {out_st_reg, out_bv_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        logic [RUN_W-1:0]  run_len;
        logic [RUN_W-1:0]  rem;
        logic              adm;
        logic [CNT_W-1:0]  free_now;
        logic [CNT_W-1:0]  st_after;
        logic              rd_reject;
        logic [ADDR_W-1:0] pos_inc;
        logic [ADDR_W-1:0] cfg_sat;

        state_next      = state_reg;
        cap_next        = cap_reg;
        wi_next         = wi_reg;
        ri_next         = ri_reg;
        stored_next     = stored_reg;
        wrem_next       = wrem_reg;
        adm_next        = adm_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        is_read_next    = is_read_reg;
        req_stored_next = req_stored_reg;
        req_free_next   = req_free_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        out_v_next      = out_v_reg;
        out_byte_next   = out_byte_reg;
        out_bv_next     = out_bv_reg;
        out_last_next   = out_last_reg;
        out_st_next     = out_st_reg;
        out_stored_next = out_stored_reg;
        out_free_next   = out_free_reg;
        mem_we          = 1'b0;
        mem_waddr       = wi_reg;
        mem_re          = 1'b0;
        mem_raddr       = pos_reg;

        free_now  = cap_reg - stored_reg;
        run_len   = (in_len == '0) ? RUN_W'(1) :
                    (in_len > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : in_len;
        rem       = wrem_reg;
        adm       = adm_reg;
        st_after  = stored_reg;
        rd_reject = (in_len > RUN_W'(MAX_RUN)) ||
                    ({{(CNT_W-RUN_W){1'b0}}, in_len} > stored_reg);
        pos_inc   = (pos_reg == cap_reg) ? '0 : pos_reg + 1'b1;
        cfg_sat   = (cfg_data == '0) ? ADDR_W'(1) :
                    (cfg_data > CAP_MAX) ? CAP_MAX : cfg_data;

        // output register drains
        if (out_v_reg && m_tready)
        begin
            out_v_next = 1'b0;
        end

        // fetched byte into the output register
        if (move)
        begin
            pend_next       = 1'b0;
            out_v_next      = 1'b1;
            out_byte_next   = rd_data_reg;
            out_bv_next     = 1'b1;
            out_last_next   = pend_last_reg;
            out_st_next     = 1'b0;
            out_stored_next = req_stored_reg;
            out_free_next   = req_free_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    cap_next    = cfg_sat;
                    wi_next     = '0;
                    ri_next     = '0;
                    stored_next = '0;
                    wrem_next   = '0;
                    adm_next    = 1'b0;
                end
                else if (s_acc)
                begin
                    case (in_func)
                        FN_WRITE:
                        begin
                            // first word of a run decides admission
                            if (wrem_reg == '0)
                            begin
                                rem = run_len;
                                adm = ({{(CNT_W-RUN_W){1'b0}}, run_len} <= free_now);
                            end
                            if (adm)
                            begin
                                mem_we    = 1'b1;
                                wi_next   = (wi_reg == cap_reg) ? '0 : wi_reg + 1'b1;
                                st_after  = stored_reg + 1'b1;
                            end
                            stored_next = st_after;
                            adm_next    = adm;
                            wrem_next   = rem - 1'b1;
                            if (rem == RUN_W'(1))
                            begin
                                out_v_next      = 1'b1;
                                out_byte_next   = '0;
                                out_bv_next     = 1'b0;
                                out_last_next   = 1'b1;
                                out_st_next     = !adm;
                                out_stored_next = st_after;
                                out_free_next   = cap_reg - st_after;
                            end
                        end
                        FN_READ, FN_PEEK:
                        begin
                            if (rd_reject || in_len == '0)
                            begin
                                out_v_next      = 1'b1;
                                out_byte_next   = '0;
                                out_bv_next     = 1'b0;
                                out_last_next   = 1'b1;
                                out_st_next     = rd_reject;
                                out_stored_next = stored_reg;
                                out_free_next   = free_now;
                            end
                            else
                            begin
                                // counts reported are those after the whole request
                                if (in_func == FN_READ)
                                begin
                                    st_after = stored_reg - {{(CNT_W-RUN_W){1'b0}}, in_len};
                                end
                                stored_next     = st_after;
                                req_stored_next = st_after;
                                req_free_next   = cap_reg - st_after;
                                pos_next        = ri_reg;
                                cnt_next        = in_len;
                                is_read_next    = (in_func == FN_READ);
                                state_next      = ST_READ;
                            end
                        end
                        FN_CLEAR:
                        begin
                            wi_next         = '0;
                            ri_next         = '0;
                            stored_next     = '0;
                            out_v_next      = 1'b1;
                            out_byte_next   = '0;
                            out_bv_next     = 1'b0;
                            out_last_next   = 1'b1;
                            out_st_next     = 1'b0;
                            out_stored_next = '0;
                            out_free_next   = cap_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // fetch the next byte once the pending slot frees up
                if (!pend_reg || move)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (cnt_reg == RUN_W'(1));
                    pos_next       = pos_inc;
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == RUN_W'(1))
                    begin
                        state_next = ST_IDLE;
                        if (is_read_reg)
                        begin
                            ri_next = pos_inc;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= in_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_MAX;
            wi_reg      <= '0;
            ri_reg      <= '0;
            stored_reg  <= '0;
            wrem_reg    <= '0;
            adm_reg     <= 1'b0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            wi_reg      <= wi_next;
            ri_reg      <= ri_next;
            stored_reg  <= stored_next;
            wrem_reg    <= wrem_next;
            adm_reg     <= adm_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            out_v_reg   <= out_v_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        is_read_reg    <= is_read_next;
        req_stored_reg <= req_stored_next;
        req_free_reg   <= req_free_next;
        pend_last_reg  <= pend_last_next;
        out_byte_reg   <= out_byte_next;
        out_bv_reg     <= out_bv_next;
        out_last_reg   <= out_last_next;
        out_st_reg     <= out_st_next;
        out_stored_reg <= out_stored_next;
        out_free_reg   <= out_free_next;
    end

endmodule
